// File: hdl/jsu_pkg.sv
package jsu_pkg;

    // Decoder mode, one-hot
    typedef enum logic [6:0] {
        M_IDLE    = 7'b0000001,
        M_STR     = 7'b0000010,
        M_ESC     = 7'b0000100,
        M_HEX1    = 7'b0001000,
        M_WANT_BS = 7'b0010000,
        M_WANT_U  = 7'b0100000,
        M_HEX2    = 7'b1000000
    } t_mode;

    // Error codes carried on the result channel
    localparam logic [3:0] E_NONE       = 4'd0;
    localparam logic [3:0] E_NO_QUOTE   = 4'd1;
    localparam logic [3:0] E_UNTERM     = 4'd2;
    localparam logic [3:0] E_END_ESC    = 4'd3;
    localparam logic [3:0] E_BAD_ESC    = 4'd4;
    localparam logic [3:0] E_END_UNI    = 4'd5;
    localparam logic [3:0] E_BAD_HEX    = 4'd6;
    localparam logic [3:0] E_NO_LOW_BS  = 4'd7;
    localparam logic [3:0] E_NO_LOW_U   = 4'd8;
    localparam logic [3:0] E_BAD_LOW    = 4'd9;
    localparam logic [3:0] E_LONE_LOW   = 4'd10;
    localparam logic [3:0] E_CTRL       = 4'd11;

    // Result group produced by one input beat: up to four output beats
    typedef struct packed {
        logic [3:0][7:0] data;      // bytes in output order
        logic [1:0]      last_idx;  // index of the final beat
        logic            done;      // closing quote seen
        logic [3:0]      err;       // error code, E_NONE if none
    } t_group;

endpackage

// File: hdl/json_string_unescape_utf8.sv
// Streaming unescaper for quoted JSON strings, emitting UTF-8.
// Input channel (i_in_valid / o_in_ready): one beat is one text byte, or an
// end-of-input mark when i_at_end is set. Output channel (o_out_valid /
// i_out_ready): one beat is one result: a decoded byte (o_byte_valid), the
// done mark of a closing quote (o_string_done) or an error (o_error_code).
// o_run_last flags the final result caused by an input beat.
// Path: an input beat is registered, then decoded and loaded into the result
// register once that register can take it, and its first result is offered
// from there.
// Throughput: one input beat per cycle while each beat yields at most one
// result and i_out_ready stays high; a \u escape that completes yields 1 to 4
// UTF-8 bytes, and the result register then holds the input side until its
// last byte is taken. Beats that yield nothing (quotes opening, backslashes,
// hex digits) load nothing into the result register.
// Reset: the decoder returns to idle, waiting for an opening quote, and both
// pipeline registers empty.
// Receiver stall: the result register holds its beat; the input register
// fills and then o_in_ready drops until results drain.
module json_string_unescape_utf8 (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_at_end,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_run_last,
    output logic       o_string_done,
    output logic [3:0] o_error_code
);

    logic            r_in_valid;
    logic [7:0]      r_in_byte;
    logic            r_in_end;
    logic            can_load;
    logic            advance;
    logic            has_result;
    jsu_pkg::t_group grp;

    assign advance    = r_in_valid & can_load;
    assign o_in_ready = !r_in_valid | advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
            r_in_end  <= i_at_end;
        end
    end

    jsu_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (advance),
        .i_byte       (r_in_byte),
        .i_end        (r_in_end),
        .o_has_result (has_result),
        .o_grp        (grp)
    );

    jsu_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (advance & has_result),
        .i_grp        (grp),
        .o_can_load   (can_load),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_byte       (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_last       (o_run_last),
        .o_done       (o_string_done),
        .o_err        (o_error_code)
    );

endmodule

// File: hdl/jsu_decode.sv
module jsu_decode (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [7:0]         i_byte,
    input  logic               i_end,
    output logic               o_has_result,
    output jsu_pkg::t_group    o_grp
);

    jsu_pkg::t_mode r_mode, n_mode;
    logic [15:0]    r_acc,  n_acc;
    logic [1:0]     r_cnt,  n_cnt;
    logic [9:0]     r_hs,   n_hs;

    logic [3:0]     err;
    logic           done;
    logic           emit1;
    logic [7:0]     byte1;
    logic           emit_cp;
    logic [20:0]    cp;
    logic [4:0]     hexd;
    logic [15:0]    full;

    // Hex digit value, bit 4 flags a valid digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        case (c) inside
            [8'h30:8'h39]: r = {1'b1, c[3:0]};
            [8'h41:8'h46],
            [8'h61:8'h66]: r = {1'b1, c[3:0] + 4'd9};
            default:       r = 5'd0;
        endcase
        return r;
    endfunction

    assign hexd = hex_val(i_byte);
    assign full = {r_acc[11:0], hexd[3:0]};

    // Work out next state and what this beat produces
    always_comb begin
        n_mode  = r_mode;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_hs    = r_hs;
        err     = jsu_pkg::E_NONE;
        done    = 1'b0;
        emit1   = 1'b0;
        byte1   = i_byte;
        emit_cp = 1'b0;
        cp      = {5'd0, full};
        if (i_end) begin
            case (r_mode)
                jsu_pkg::M_STR:     err = jsu_pkg::E_UNTERM;
                jsu_pkg::M_ESC:     err = jsu_pkg::E_END_ESC;
                jsu_pkg::M_HEX1,
                jsu_pkg::M_HEX2:    err = jsu_pkg::E_END_UNI;
                jsu_pkg::M_WANT_BS: err = jsu_pkg::E_NO_LOW_BS;
                jsu_pkg::M_WANT_U:  err = jsu_pkg::E_NO_LOW_U;
                default:            err = jsu_pkg::E_NO_QUOTE;
            endcase
        end else begin
            case (r_mode)
                jsu_pkg::M_STR: begin
                    if (i_byte == 8'h22) begin
                        done   = 1'b1;
                        n_mode = jsu_pkg::M_IDLE;
                    end else if (i_byte == 8'h5C) begin
                        n_mode = jsu_pkg::M_ESC;
                    end else if (i_byte < 8'h20) begin
                        err = jsu_pkg::E_CTRL;
                    end else begin
                        emit1 = 1'b1;
                    end
                end
                jsu_pkg::M_ESC: begin
                    n_mode = jsu_pkg::M_STR;
                    emit1  = 1'b1;
                    case (i_byte)
                        8'h22, 8'h5C, 8'h2F: byte1 = i_byte;
                        8'h62: byte1 = 8'h08;
                        8'h66: byte1 = 8'h0C;
                        8'h6E: byte1 = 8'h0A;
                        8'h72: byte1 = 8'h0D;
                        8'h74: byte1 = 8'h09;
                        8'h75: begin
                            emit1  = 1'b0;
                            n_mode = jsu_pkg::M_HEX1;
                            n_acc  = 16'd0;
                            n_cnt  = 2'd0;
                        end
                        default: begin
                            emit1 = 1'b0;
                            err   = jsu_pkg::E_BAD_ESC;
                        end
                    endcase
                end
                jsu_pkg::M_HEX1,
                jsu_pkg::M_HEX2: begin
                    if (!hexd[4]) begin
                        err = jsu_pkg::E_BAD_HEX;
                    end else begin
                        n_acc = full;
                        if (r_cnt != 2'd3) begin
                            n_cnt = r_cnt + 2'd1;
                        end else begin
                            n_cnt = 2'd0;
                            if (r_mode == jsu_pkg::M_HEX1) begin
                                // high surrogate waits for its pair
                                if (full[15:10] == 6'b110110) begin
                                    n_hs   = full[9:0];
                                    n_mode = jsu_pkg::M_WANT_BS;
                                end else if (full[15:10] == 6'b110111) begin
                                    err = jsu_pkg::E_LONE_LOW;
                                end else begin
                                    n_mode  = jsu_pkg::M_STR;
                                    emit_cp = 1'b1;
                                end
                            end else begin
                                if (full[15:10] != 6'b110111) begin
                                    err = jsu_pkg::E_BAD_LOW;
                                end else begin
                                    n_mode  = jsu_pkg::M_STR;
                                    emit_cp = 1'b1;
                                    cp      = 21'h10000 + {1'b0, r_hs, full[9:0]};
                                end
                            end
                        end
                    end
                end
                jsu_pkg::M_WANT_BS: begin
                    if (i_byte != 8'h5C) begin
                        err = jsu_pkg::E_NO_LOW_BS;
                    end else begin
                        n_mode = jsu_pkg::M_WANT_U;
                    end
                end
                jsu_pkg::M_WANT_U: begin
                    if (i_byte != 8'h75) begin
                        err = jsu_pkg::E_NO_LOW_U;
                    end else begin
                        n_mode = jsu_pkg::M_HEX2;
                        n_acc  = 16'd0;
                        n_cnt  = 2'd0;
                    end
                end
                default: begin
                    // idle, and any unused code: expect the opening quote
                    if (i_byte == 8'h22) begin
                        n_mode = jsu_pkg::M_STR;
                    end else begin
                        err = jsu_pkg::E_NO_QUOTE;
                    end
                end
            endcase
        end
        // Any error drops the string and clears the state
        if (err != jsu_pkg::E_NONE) begin
            n_mode = jsu_pkg::M_IDLE;
            n_acc  = 16'd0;
            n_cnt  = 2'd0;
            n_hs   = 10'd0;
        end
    end

    // Build the result group
    always_comb begin
        o_grp          = '0;
        o_grp.err      = err;
        o_grp.done     = done;
        o_has_result   = (err != jsu_pkg::E_NONE) | done | emit1 | emit_cp;
        if (err == jsu_pkg::E_NONE && !done) begin
            if (emit1) begin
                o_grp.data[0] = byte1;
            end else if (cp <= 21'h7F) begin
                o_grp.data[0] = cp[7:0];
            end else if (cp <= 21'h7FF) begin
                o_grp.data[0]  = {3'b110, cp[10:6]};
                o_grp.data[1]  = {2'b10, cp[5:0]};
                o_grp.last_idx = 2'd1;
            end else if (cp <= 21'hFFFF) begin
                o_grp.data[0]  = {4'b1110, cp[15:12]};
                o_grp.data[1]  = {2'b10, cp[11:6]};
                o_grp.data[2]  = {2'b10, cp[5:0]};
                o_grp.last_idx = 2'd2;
            end else begin
                o_grp.data[0]  = {5'b11110, cp[20:18]};
                o_grp.data[1]  = {2'b10, cp[17:12]};
                o_grp.data[2]  = {2'b10, cp[11:6]};
                o_grp.data[3]  = {2'b10, cp[5:0]};
                o_grp.last_idx = 2'd3;
            end
        end
    end

    // Advance state on each consumed beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= jsu_pkg::M_IDLE;
            r_acc  <= 16'd0;
            r_cnt  <= 2'd0;
            r_hs   <= 10'd0;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_cnt  <= n_cnt;
            r_hs   <= n_hs;
        end
    end

endmodule

// File: hdl/jsu_out.sv
module jsu_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  jsu_pkg::t_group    i_grp,
    output logic               o_can_load,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_byte,
    output logic               o_byte_valid,
    output logic               o_last,
    output logic               o_done,
    output logic [3:0]         o_err
);

    jsu_pkg::t_group r_grp;
    logic            r_valid;
    logic [1:0]      r_idx;
    logic            take;
    logic            is_last;

    assign is_last    = (r_idx == r_grp.last_idx);
    assign take       = r_valid & i_ready;
    assign o_can_load = !r_valid | (take & is_last);

    assign o_valid      = r_valid;
    assign o_byte       = r_grp.data[r_idx];
    assign o_byte_valid = (r_grp.err == jsu_pkg::E_NONE) & !r_grp.done;
    assign o_last       = is_last;
    assign o_done       = r_grp.done;
    assign o_err        = r_grp.err;

    // Hold the group, step through its beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (take) begin
            if (is_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_grp <= i_grp;
        end
    end

endmodule

// File: hdl/jsu_checker.sv
module jsu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte,
    input logic       o_byte_valid,
    input logic       o_run_last,
    input logic       o_string_done,
    input logic [3:0] o_error_code
);

    // A data beat is never also a done or error beat
    a_kind_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_valid |-> !o_string_done && o_error_code == jsu_pkg::E_NONE)
        else $error("data beat carries done or error");

    // Done and error results stand alone and close their run
    a_term_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_string_done || o_error_code != jsu_pkg::E_NONE) |-> o_run_last)
        else $error("done or error beat not last of its run");

    // Error codes stay within the defined set
    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_error_code <= jsu_pkg::E_CTRL)
        else $error("error code out of range");

    // A stalled beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_run_last) && $stable(o_error_code))
        else $error("stalled beat changed");

    // Nothing comes out the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_out_byte    (o_out_byte),
    .o_byte_valid  (o_byte_valid),
    .o_run_last    (o_run_last),
    .o_string_done (o_string_done),
    .o_error_code  (o_error_code)
);
